/* rtl/snt_pkg.sv */
// ----------------------------------------------------------------------------
// snt_pkg
// Shared types and constants of the Sobel gradient and edge thinning core.
// ----------------------------------------------------------------------------
package snt_pkg;

    localparam int PIX_W  = 8;
    localparam int CFG_W  = 12;
    localparam int ROW_W  = 13;
    localparam int GRAD_W = 11;
    localparam int ABS_W  = 10;
    localparam int SQ_W   = 20;
    localparam int MAG_W  = 21;

    localparam int DIM_MIN    = 3;
    localparam int WIDTH_RST  = 640;
    localparam int HEIGHT_RST = 480;

    // slope tests: SCALE*|gy| against STEEP*|gx| and SHALLOW*|gx|
    localparam int SLOPE_W       = 22;
    localparam int SLOPE_SCALE   = 1000;
    localparam int SLOPE_STEEP   = 2414;
    localparam int SLOPE_SHALLOW = 414;

    typedef enum logic [2:0] {
        AXIS_VERTICAL   = 3'd0,
        AXIS_ANTIDIAG   = 3'd1,
        AXIS_HORIZONTAL = 3'd2,
        AXIS_DIAGONAL   = 3'd3,
        AXIS_NONE       = 3'd4
    } t_axis;

    typedef enum logic {
        KIND_PIXEL = 1'b0,
        KIND_PAD   = 1'b1
    } t_kind;

    typedef enum logic {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic act;
        logic m_in;
        logic q_in;
        logic q_val;
        logic q_last;
    } t_tag;

endpackage

/* rtl/snt_pix_if.sv */
// ----------------------------------------------------------------------------
// snt_pix_if
// Pixel item channel: valid/ready handshake with kind and pixel payload.
// ----------------------------------------------------------------------------
interface snt_pix_if import snt_pkg::*; ();
    logic                 valid;
    logic                 ready;
    t_kind                kind;
    logic [PIX_W-1:0]     pixel;

    modport source (output valid, kind, pixel, input ready);
    modport sink   (input valid, kind, pixel, output ready);
endinterface

/* rtl/snt_res_if.sv */
// ----------------------------------------------------------------------------
// snt_res_if
// Result item channel: valid/ready handshake with the edge result payload.
// ----------------------------------------------------------------------------
interface snt_res_if import snt_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 valid_res;
    logic                 edge_res;
    t_axis                axis;
    logic [MAG_W-1:0]     grad_squared;
    logic                 frame_last;

    modport source (output valid, valid_res, edge_res, axis, grad_squared, frame_last,
                    input ready);
    modport sink   (input valid, valid_res, edge_res, axis, grad_squared, frame_last,
                    output ready);
endinterface

/* rtl/snt_ram.sv */
// ----------------------------------------------------------------------------
// snt_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module snt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/sobel_nonmax_edge_thinning_core.sv */
// ----------------------------------------------------------------------------
// sobel_nonmax_edge_thinning_core
// Sobel gradient, four-axis quantization and non-maximum suppression over a
// raster-order 8-bit pixel stream.
// ----------------------------------------------------------------------------
// Takes one item per clock when the result side does not stall and gives one
// result item per item; the rate is set by the three line RAMs (pixel, magnitude,
// axis), each MAX_WIDTH deep with one read and one write per item. The result
// for a pixel arrives with the item two rows and two columns later, so 2*W+2
// padding items drain a frame.
// Padding inside the image is a no-op item with an empty result. A write of
// image_width or image_height restarts the frame; write them only while the
// block is idle. The line RAMs need no clearing after reset.
module sobel_nonmax_edge_thinning_core import snt_pkg::*; #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  t_cfg_idx         i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    snt_pix_if.sink          i_pix,
    snt_res_if.source        o_res
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int PW = ((CW + 1 > ROW_W) ? CW + 1 : ROW_W) + 1;

    typedef logic signed [PW-1:0] t_pos;

    localparam t_pos P0   = t_pos'(0);
    localparam t_pos P1   = t_pos'(1);
    localparam t_pos P2   = t_pos'(2);
    localparam t_pos PMIN = t_pos'(DIM_MIN);
    localparam t_pos WMAX = t_pos'(MAX_WIDTH);
    localparam t_pos WRST = t_pos'((WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RST);
    localparam t_pos HRST = t_pos'(HEIGHT_RST);

    // configuration and position counters
    t_pos             r_width, r_height;
    t_pos             n_width, n_height, cfg_val;
    logic [CW-1:0]    r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;

    t_pos             ic, ir, mc, mr, qc, qr, nc, nr;
    logic             in_image;
    t_tag             s0_tag;
    logic [PIX_W-1:0] s0_pix;

    // handshake
    logic free1, free2, free3, free4, free5, free6;
    logic mv1, mv2, mv3, mv4, mv5;
    logic accept;
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;

    // stage payloads
    t_tag                     r_s1_tag, r_s2_tag, r_s3_tag, r_s4_tag, r_s5_tag;
    logic [PIX_W-1:0]         r_s1_pix;
    logic [CW-1:0]            r_s1_col;
    logic [CW-1:0]            r_s1_mcol, r_s2_mcol, r_s3_mcol, r_s4_mcol;
    logic signed [GRAD_W-1:0] r_s3_gx, r_s3_gy;
    logic [SQ_W-1:0]          r_s4_sqx, r_s4_sqy;
    t_axis                    r_s4_ax, r_s5_qaxis, r_axis_delay;

    logic [PIX_W-1:0] r_pwin [3][3];
    logic [MAG_W-1:0] r_mwin [3][3];

    // line RAM ports
    logic                  pl_re, pl_we;
    logic [2*PIX_W-1:0]    pl_wdata, pl_rdata;
    logic                  mg_re, mg_we;
    logic [2*MAG_W-1:0]    mg_wdata, mg_rdata;
    logic [$bits(t_axis)-1:0] ax_wdata, ax_rdata;

    // gradient and suppression logic
    logic [ABS_W-1:0]         gx_pos, gx_neg, gy_pos, gy_neg;
    logic signed [GRAD_W-1:0] s2_gx, s2_gy;
    logic [ABS_W-1:0]         s3_a, s3_b;
    logic [SLOPE_W-1:0]       b_scaled, a_steep, a_shallow;
    logic                     s3_live, s3_same_sign;
    t_axis                    s3_ax;
    logic [SQ_W-1:0]          s3_sqx, s3_sqy;
    logic [MAG_W-1:0]         s4_mag;
    logic [MAG_W-1:0]         s5_c, s5_n1, s5_n2;
    t_axis                    s5_axis_sel;
    logic                     s5_valid_res, s5_edge, s5_last;
    t_axis                    s5_axis;
    logic [MAG_W-1:0]         s5_grad;

    logic             r_o_valid_res, r_o_edge, r_o_last;
    t_axis            r_o_axis;
    logic [MAG_W-1:0] r_o_grad;

    // ------------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------------
    always_comb begin
        cfg_val  = t_pos'(i_cfg_data);
        n_width  = cfg_val;
        n_height = cfg_val;
        if (cfg_val < PMIN) begin
            n_width  = PMIN;
            n_height = PMIN;
        end else if (cfg_val > WMAX) begin
            n_width = WMAX;
        end
    end

    // ------------------------------------------------------------------------
    // item position in the extended frame
    // ------------------------------------------------------------------------
    always_comb begin
        ic       = t_pos'(r_col);
        ir       = t_pos'(r_row);
        in_image = ir < r_height;
        s0_pix   = in_image ? i_pix.pixel : '0;

        if (ic == P0) begin
            mc = r_width - P1;
            mr = ir - P2;
        end else begin
            mc = ic - P1;
            mr = ir - P1;
        end
        if (mc == P0) begin
            qc = r_width - P1;
            qr = mr - P2;
        end else begin
            qc = mc - P1;
            qr = mr - P1;
        end

        s0_tag.act    = !(i_pix.kind == KIND_PAD && in_image);
        s0_tag.m_in   = (mr >= P1) && (mr <= r_height - P2) &&
                        (mc >= P1) && (mc <= r_width - P2);
        s0_tag.q_in   = (qr >= P1) && (qr <= r_height - P2) &&
                        (qc >= P1) && (qc <= r_width - P2);
        s0_tag.q_val  = qr >= P0;
        s0_tag.q_last = (qr == r_height - P1) && (qc == r_width - P1);

        nc = ic + P1;
        nr = ir;
        if (nc >= r_width) begin
            nc = P0;
            nr = ir + P1;
        end
        if (nr >= r_height + P2 && nc >= P2) begin
            nc = P0;
            nr = P0;
        end
        n_col = nc[CW-1:0];
        n_row = nr[ROW_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WRST;
            r_height <= HRST;
            r_col    <= '0;
            r_row    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IMAGE_WIDTH:  r_width  <= n_width;
                CFG_IMAGE_HEIGHT: r_height <= n_height;
                default: ;
            endcase
            r_col <= '0;
            r_row <= '0;
        end else if (accept && s0_tag.act) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // ------------------------------------------------------------------------
    // stage handshake
    // ------------------------------------------------------------------------
    assign free6 = !r_v6 || o_res.ready;
    assign free5 = !r_v5 || free6;
    assign free4 = !r_v4 || free5;
    assign free3 = !r_v3 || free4;
    assign free2 = !r_v2 || free3;
    assign free1 = !r_v1 || free2;
    assign mv1   = r_v1 && free2;
    assign mv2   = r_v2 && free3;
    assign mv3   = r_v3 && free4;
    assign mv4   = r_v4 && free5;
    assign mv5   = r_v5 && free6;

    assign i_pix.ready = free1;
    assign accept      = i_pix.valid && free1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            if (free1) r_v1 <= accept;
            if (free2) r_v2 <= mv1;
            if (free3) r_v3 <= mv2;
            if (free4) r_v4 <= mv3;
            if (free5) r_v5 <= mv4;
            if (free6) r_v6 <= mv5;
        end
    end

    // ------------------------------------------------------------------------
    // stage 1: pixel line RAM and pixel window
    // ------------------------------------------------------------------------
    assign pl_re    = accept && s0_tag.act;
    assign pl_we    = mv1 && r_s1_tag.act;
    assign pl_wdata = {pl_rdata[PIX_W-1:0], r_s1_pix};

    snt_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_pixel_lines (
        .i_clk   (i_clk),
        .i_we    (pl_we),
        .i_waddr (r_s1_col),
        .i_wdata (pl_wdata),
        .i_re    (pl_re),
        .i_raddr (r_col),
        .o_rdata (pl_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (free1) begin
            r_s1_tag  <= s0_tag;
            r_s1_pix  <= s0_pix;
            r_s1_col  <= r_col;
            r_s1_mcol <= mc[CW-1:0];
        end
        if (pl_we) begin
            for (int r = 0; r < 3; r++) begin
                r_pwin[r][0] <= r_pwin[r][1];
                r_pwin[r][1] <= r_pwin[r][2];
            end
            r_pwin[0][2] <= pl_rdata[2*PIX_W-1:PIX_W];
            r_pwin[1][2] <= pl_rdata[PIX_W-1:0];
            r_pwin[2][2] <= r_s1_pix;
        end
    end

    // ------------------------------------------------------------------------
    // stage 2: Sobel gradients
    // ------------------------------------------------------------------------
    always_comb begin
        gx_pos = ABS_W'(r_pwin[0][2]) + (ABS_W'(r_pwin[1][2]) << 1) + ABS_W'(r_pwin[2][2]);
        gx_neg = ABS_W'(r_pwin[0][0]) + (ABS_W'(r_pwin[1][0]) << 1) + ABS_W'(r_pwin[2][0]);
        gy_pos = ABS_W'(r_pwin[2][0]) + (ABS_W'(r_pwin[2][1]) << 1) + ABS_W'(r_pwin[2][2]);
        gy_neg = ABS_W'(r_pwin[0][0]) + (ABS_W'(r_pwin[0][1]) << 1) + ABS_W'(r_pwin[0][2]);
        s2_gx  = $signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg});
        s2_gy  = $signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg});
    end

    always_ff @(posedge i_clk) begin
        if (free2) begin
            r_s2_tag  <= r_s1_tag;
            r_s2_mcol <= r_s1_mcol;
        end
        if (free3) begin
            r_s3_tag  <= r_s2_tag;
            r_s3_mcol <= r_s2_mcol;
            r_s3_gx   <= s2_gx;
            r_s3_gy   <= s2_gy;
        end
    end

    // ------------------------------------------------------------------------
    // stage 3: squares and axis quantization
    // ------------------------------------------------------------------------
    always_comb begin
        s3_a = r_s3_gx[GRAD_W-1] ? ABS_W'(-r_s3_gx) : ABS_W'(r_s3_gx);
        s3_b = r_s3_gy[GRAD_W-1] ? ABS_W'(-r_s3_gy) : ABS_W'(r_s3_gy);

        b_scaled  = SLOPE_W'(s3_b) * SLOPE_W'(SLOPE_SCALE);
        a_steep   = SLOPE_W'(s3_a) * SLOPE_W'(SLOPE_STEEP);
        a_shallow = SLOPE_W'(s3_a) * SLOPE_W'(SLOPE_SHALLOW);

        s3_live      = r_s3_tag.m_in && (r_s3_gx != '0 || r_s3_gy != '0);
        s3_same_sign = (r_s3_gx > 0) == (r_s3_gy > 0);

        if (!s3_live) begin
            s3_ax = AXIS_NONE;
        end else if (b_scaled > a_steep) begin
            s3_ax = AXIS_VERTICAL;
        end else if (b_scaled > a_shallow) begin
            s3_ax = s3_same_sign ? AXIS_DIAGONAL : AXIS_ANTIDIAG;
        end else begin
            s3_ax = AXIS_HORIZONTAL;
        end

        s3_sqx = s3_live ? SQ_W'(s3_a) * SQ_W'(s3_a) : '0;
        s3_sqy = s3_live ? SQ_W'(s3_b) * SQ_W'(s3_b) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (free4) begin
            r_s4_tag  <= r_s3_tag;
            r_s4_mcol <= r_s3_mcol;
            r_s4_sqx  <= s3_sqx;
            r_s4_sqy  <= s3_sqy;
            r_s4_ax   <= s3_ax;
        end
    end

    // ------------------------------------------------------------------------
    // stage 4: magnitude and axis line RAMs, magnitude window
    // ------------------------------------------------------------------------
    assign s4_mag   = MAG_W'(r_s4_sqx) + MAG_W'(r_s4_sqy);
    assign mg_re    = mv3 && r_s3_tag.act;
    assign mg_we    = mv4 && r_s4_tag.act;
    assign mg_wdata = {mg_rdata[MAG_W-1:0], s4_mag};
    assign ax_wdata = r_s4_ax;

    snt_ram #(
        .WIDTH (2 * MAG_W),
        .DEPTH (MAX_WIDTH)
    ) u_magnitude_lines (
        .i_clk   (i_clk),
        .i_we    (mg_we),
        .i_waddr (r_s4_mcol),
        .i_wdata (mg_wdata),
        .i_re    (mg_re),
        .i_raddr (r_s3_mcol),
        .o_rdata (mg_rdata)
    );

    snt_ram #(
        .WIDTH ($bits(t_axis)),
        .DEPTH (MAX_WIDTH)
    ) u_axis_line (
        .i_clk   (i_clk),
        .i_we    (mg_we),
        .i_waddr (r_s4_mcol),
        .i_wdata (ax_wdata),
        .i_re    (mg_re),
        .i_raddr (r_s3_mcol),
        .o_rdata (ax_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (free5) begin
            r_s5_tag   <= r_s4_tag;
            r_s5_qaxis <= r_axis_delay;
        end
        if (mg_we) begin
            for (int r = 0; r < 3; r++) begin
                r_mwin[r][0] <= r_mwin[r][1];
                r_mwin[r][1] <= r_mwin[r][2];
            end
            r_mwin[0][2] <= mg_rdata[2*MAG_W-1:MAG_W];
            r_mwin[1][2] <= mg_rdata[MAG_W-1:0];
            r_mwin[2][2] <= s4_mag;
            r_axis_delay <= t_axis'(ax_rdata);
        end
    end

    // ------------------------------------------------------------------------
    // stage 5: non-maximum suppression
    // ------------------------------------------------------------------------
    always_comb begin
        s5_c        = r_mwin[1][1];
        s5_axis_sel = r_s5_qaxis;
        case (r_s5_qaxis)
            AXIS_VERTICAL: begin
                s5_n1 = r_mwin[0][1];
                s5_n2 = r_mwin[2][1];
            end
            AXIS_ANTIDIAG: begin
                s5_n1 = r_mwin[0][2];
                s5_n2 = r_mwin[2][0];
            end
            AXIS_HORIZONTAL: begin
                s5_n1 = r_mwin[1][0];
                s5_n2 = r_mwin[1][2];
            end
            AXIS_DIAGONAL: begin
                s5_n1 = r_mwin[0][0];
                s5_n2 = r_mwin[2][2];
            end
            default: begin
                s5_n1       = s5_c;
                s5_n2       = s5_c;
                s5_axis_sel = AXIS_NONE;
            end
        endcase

        s5_valid_res = 1'b0;
        s5_edge      = 1'b0;
        s5_axis      = AXIS_NONE;
        s5_grad      = '0;
        s5_last      = 1'b0;
        if (r_s5_tag.act) begin
            s5_valid_res = r_s5_tag.q_val;
            s5_last      = r_s5_tag.q_last;
            if (r_s5_tag.q_in) begin
                s5_grad = s5_c;
                s5_axis = s5_axis_sel;
                s5_edge = (s5_c > s5_n1) && (s5_c > s5_n2);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (free6) begin
            r_o_valid_res <= s5_valid_res;
            r_o_edge      <= s5_edge;
            r_o_axis      <= s5_axis;
            r_o_grad      <= s5_grad;
            r_o_last      <= s5_last;
        end
    end

    assign o_res.valid        = r_v6;
    assign o_res.valid_res    = r_o_valid_res;
    assign o_res.edge_res     = r_o_edge;
    assign o_res.axis         = r_o_axis;
    assign o_res.grad_squared = r_o_grad;
    assign o_res.frame_last   = r_o_last;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_pixel_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pl_we && pl_re) |-> (r_s1_col != r_col))
        else $error("pixel line read and write collide");

    a_mag_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mg_we && mg_re) |-> (r_s4_mcol != r_s3_mcol))
        else $error("magnitude line read and write collide");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        t_pos'(r_col) < r_width)
        else $error("column counter beyond image width");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v6 |-> i_pix.ready)
        else $error("input stalled with empty result register");

    a_last_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v6 && r_o_last) |-> r_o_valid_res)
        else $error("frame end on a result without pixel");

endmodule
